[rtl/core/circular_fifo_with_close_unit_macros.svh]
// Assertion helpers used by the controller of the circular FIFO with close.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef CIRCULAR_FIFO_WITH_CLOSE_UNIT_MACROS_SVH
`define CIRCULAR_FIFO_WITH_CLOSE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cfwc_pkg.sv]
`default_nettype none

package cfwc_pkg;

  // Widths of the fixed fields on the ports.
  localparam int PORT_W = 32;
  localparam int LEN_W  = 5;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_CLOSED = 2'd3
  } resp_code_t;

  // Register indexes on the configuration port.
  localparam logic REG_QUEUE_LENGTH = 1'b0;

  // Configuration as seen by the controller.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             clear_ptrs;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/cfwc_store.sv]
`default_nettype none

module cfwc_store #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read word is held until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/cfwc_regs.sv]
`default_nettype none

module cfwc_regs import cfwc_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [PORT_W-1:0] pwdata,
  output logic      [PORT_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              fill_zero,
  output cfg_t                   cfg
);

  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'((DEPTH < 31) ? DEPTH : 31);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'((DEPTH < 16) ? DEPTH : 16);

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic [LEN_W-1:0] wr_value;
  logic             wr_hit;

  assign pready   = 1'b1;
  assign wr_value = pwdata[LEN_W-1:0];
  // A length write counts only while the FIFO holds nothing.
  assign wr_hit   = psel && penable && pwrite && (paddr[2] == REG_QUEUE_LENGTH) && fill_zero;

  always_comb begin
    if (wr_value == '0) begin
      len_next = LEN_W'(1);
    end else if (32'(wr_value) > DEPTH) begin
      len_next = LEN_MAX;
    end else begin
      len_next = wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_RESET;
    end else if (wr_hit) begin
      len <= len_next;
    end
  end

  assign prdata         = (paddr[2] == REG_QUEUE_LENGTH) ? PORT_W'(len) : '0;
  assign cfg.len        = len;
  assign cfg.clear_ptrs = wr_hit;

endmodule

`default_nettype wire

[rtl/core/cfwc_ctrl.sv]
`default_nettype none

`include "circular_fifo_with_close_unit_macros.svh"

module cfwc_ctrl import cfwc_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  cfg_t                       cfg,
  output logic                       fill_zero,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic [1:0]            operation,
  input  wire logic [PORT_W-1:0]     data_in,
  input  wire logic                  drain_on_close,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic      [PORT_W-1:0]     data_out,
  output logic                       data_valid,
  output logic      [1:0]            status,
  output logic      [LEN_W-1:0]      occupancy,
  output logic                       empty_flag,
  output logic                       full_flag,
  output logic                       last,
  output logic                       mem_we,
  output logic      [AW-1:0]         mem_waddr,
  output logic      [DATA_WIDTH-1:0] mem_wdata,
  output logic                       mem_re,
  output logic      [AW-1:0]         mem_raddr,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_t;

  state_t           state;
  logic [AW-1:0]    rp;
  logic [AW-1:0]    wp;
  logic [LEN_W-1:0] fill;
  logic             closed;
  logic             draining;

  logic             out_free;
  logic             item_acc;
  logic             wait_load;
  logic             more_drain;
  logic [LEN_W-1:0] fill_inc;
  logic [LEN_W-1:0] fill_dec;

  // Decode of an accepted item.
  logic             put_write;
  logic             take_word;
  logic             go_wait;
  logic             go_drain;
  logic             set_closed;
  resp_code_t       imm_status;
  logic [LEN_W-1:0] imm_occ;

  logic [63:0]      in_wide;
  logic [63:0]      rd_wide;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p, input logic [LEN_W-1:0] l);
    if (32'(p) + 32'd1 >= 32'(l)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE) || !out_free;
  assign item_acc   = item_valid && !item_stall;
  assign wait_load  = (state == S_WAIT) && out_free;
  assign more_drain = wait_load && draining && (fill != '0);
  assign fill_inc   = fill + LEN_W'(1);
  assign fill_dec   = fill - LEN_W'(1);
  assign fill_zero  = (fill == '0);

  always_comb begin
    put_write  = 1'b0;
    take_word  = 1'b0;
    go_wait    = 1'b0;
    go_drain   = 1'b0;
    set_closed = 1'b0;
    imm_status = ST_OK;
    imm_occ    = fill;
    case (op_t'(operation))
      OP_PUT: begin
        if (closed) begin
          imm_status = ST_CLOSED;
        end else if (fill >= cfg.len) begin
          imm_status = ST_FULL;
        end else begin
          put_write = 1'b1;
          imm_occ   = fill_inc;
        end
      end
      OP_GET: begin
        if (closed) begin
          imm_status = ST_CLOSED;
        end else if (fill == '0) begin
          imm_status = ST_EMPTY;
        end else begin
          take_word = 1'b1;
          go_wait   = 1'b1;
        end
      end
      OP_PEEK: begin
        go_wait = (fill != '0);
      end
      OP_CLOSE: begin
        set_closed = 1'b1;
        if (drain_on_close && (fill != '0)) begin
          take_word = 1'b1;
          go_wait   = 1'b1;
          go_drain  = 1'b1;
        end
      end
      default: begin
        imm_status = ST_OK;
      end
    endcase
  end

  // Every read is of the oldest word.
  assign in_wide   = 64'(data_in);
  assign rd_wide   = 64'(mem_rdata);
  assign mem_we    = item_acc && put_write;
  assign mem_waddr = wp;
  assign mem_wdata = in_wide[DATA_WIDTH-1:0];
  assign mem_re    = (item_acc && go_wait) || more_drain;
  assign mem_raddr = rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      rp           <= '0;
      wp           <= '0;
      fill         <= '0;
      closed       <= 1'b0;
      draining     <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg.clear_ptrs) begin
        rp <= '0;
        wp <= '0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            if (set_closed) begin
              closed <= 1'b1;
            end
            if (put_write) begin
              wp   <= advance(wp, cfg.len);
              fill <= fill_inc;
            end
            if (take_word) begin
              rp   <= advance(rp, cfg.len);
              fill <= fill_dec;
            end
            if (go_wait) begin
              state    <= S_WAIT;
              draining <= go_drain;
            end else begin
              result_valid <= 1'b1;
              data_out     <= '0;
              data_valid   <= 1'b0;
              status       <= imm_status;
              occupancy    <= imm_occ;
              empty_flag   <= (imm_occ == '0);
              full_flag    <= (imm_occ == cfg.len);
              last         <= 1'b1;
            end
          end
        end
        S_WAIT: begin
          if (wait_load) begin
            // The word for this transfer is already out of the array; for a get or a
            // drain the count already reflects its removal.
            result_valid <= 1'b1;
            data_out     <= rd_wide[PORT_W-1:0];
            data_valid   <= 1'b1;
            status       <= ST_OK;
            occupancy    <= fill;
            empty_flag   <= (fill == '0);
            full_flag    <= (fill == cfg.len);
            last         <= !draining || (fill == '0);
            if (more_drain) begin
              rp   <= advance(rp, cfg.len);
              fill <= fill_dec;
            end else begin
              state    <= S_IDLE;
              draining <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CFWC_ASSERT_NOW(a_fill_bound, 1'b1, fill <= cfg.len, "fill count above active length")
  `CFWC_ASSERT_NEXT(a_closed_sticks, closed, closed, "closed flag cleared without reset")
  `CFWC_ASSERT_NEXT(a_get_takes_one, item_acc && take_word && !go_drain,
    fill == $past(fill) - 5'd1, "get did not remove exactly one word")
  `CFWC_ASSERT_NEXT(a_drain_ends, wait_load && draining && (fill == '0),
    (state == S_IDLE) && result_valid && last, "drain did not end on its last word")

endmodule

`default_nettype wire

[rtl/core/circular_fifo_with_close_unit.sv]
`default_nettype none

// Ring-buffer FIFO with a close operation. Each transfer on the item channel
// carries one operation: put, get, peek or close. Put, a failed get, a peek
// on an empty FIFO and a close without draining present their result in the
// output register in the cycle after they are accepted. A successful get and
// a peek on a non-empty FIFO first read the word from the synchronous array
// and wait for it in the wait state before the result is registered. A
// draining close makes one array read per stored word and produces one result
// transfer per word with last set on the final one. The item channel stalls
// while a read is outstanding and while the output register holds a result
// that has not been taken. There is no clearing pass after reset: the array
// holds no reset value and only written entries are ever read.
module circular_fifo_with_close_unit import cfwc_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,

  // Configuration port. Register 0 at byte address 0 is queue_length.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [PORT_W-1:0] pwdata,
  output logic      [PORT_W-1:0] prdata,
  output logic                   pready,

  // Item channel.
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [1:0]        operation,
  input  wire logic [PORT_W-1:0] data_in,
  input  wire logic              drain_on_close,

  // Result channel.
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic      [PORT_W-1:0] data_out,
  output logic                   data_valid,
  output logic      [1:0]        status,
  output logic      [LEN_W-1:0]  occupancy,
  output logic                   empty_flag,
  output logic                   full_flag,
  output logic                   last
);

  // Pointer width follows the array depth.
  localparam int AW = $clog2(DEPTH);

  cfg_t                  cfg;
  logic                  fill_zero;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // The length register. A write is ignored unless the FIFO is empty, and an
  // accepted write also returns both pointers to the first slot.
  cfwc_regs #(
    .DEPTH (DEPTH)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .fill_zero (fill_zero),
    .cfg       (cfg)
  );

  // Pointers, fill count, closed flag, sequencing and the output register.
  cfwc_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .fill_zero      (fill_zero),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .data_in        (data_in),
    .drain_on_close (drain_on_close),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .data_out       (data_out),
    .data_valid     (data_valid),
    .status         (status),
    .occupancy      (occupancy),
    .empty_flag     (empty_flag),
    .full_flag      (full_flag),
    .last           (last),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  // Slot array. Writes and reads never meet on one edge, since a put and the
  // read that could follow it are always separate transfers.
  cfwc_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

[dv/tb_top.sv]
module tb_top import cfwc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // The receiver holds off this many cycles during the pressure phase, and
  // the watchdog gives up after this many cycles in which no transfer
  // happens on either channel. The limit sits far above the longest
  // legitimate silence, which is the hold-off itself.
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PCT       = 12;
  localparam int PRINT_CAP      = 40;

  // One result as the FIFO reports it.
  typedef struct packed {
    logic [31:0] word;
    logic        word_valid;
    resp_code_t  status;
    logic [4:0]  occ;
    logic        empty;
    logic        full;
    logic        last;
  } fifo_result_t;

  // One row of the directed table. Where typed is set, the expected result
  // is written in the row; otherwise the predictor supplies it.
  typedef struct packed {
    op_t          op;
    logic [31:0]  data;
    logic         drain;
    logic         typed;
    fifo_result_t want;
  } fifo_row_t;

  // Directed rows for an open FIFO right after reset (length 16). The table
  // starts on an empty FIFO, moves the extreme words through it and leaves
  // one word stored, so that the next length write must be ignored.
  localparam fifo_row_t OPEN_ROWS [11] = '{
    '{OP_GET,  32'h0000_0000, 1'b0, 1'b1,
      '{32'h0, 1'b0, ST_EMPTY, 5'd0, 1'b1, 1'b0, 1'b1}},
    '{OP_PEEK, 32'h0000_0000, 1'b1, 1'b1,
      '{32'h0, 1'b0, ST_OK, 5'd0, 1'b1, 1'b0, 1'b1}},
    '{OP_PUT,  32'h0000_0000, 1'b0, 1'b1,
      '{32'h0, 1'b0, ST_OK, 5'd1, 1'b0, 1'b0, 1'b1}},
    '{OP_PUT,  32'hFFFF_FFFF, 1'b1, 1'b1,
      '{32'h0, 1'b0, ST_OK, 5'd2, 1'b0, 1'b0, 1'b1}},
    '{OP_PEEK, 32'h1234_5678, 1'b0, 1'b0, '0},
    '{OP_GET,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{OP_PUT,  32'hA5A5_5A5A, 1'b1, 1'b0, '0},
    '{OP_GET,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_GET,  32'h0000_0000, 1'b1, 1'b0, '0},
    '{OP_GET,  32'h0000_0000, 1'b0, 1'b1,
      '{32'h0, 1'b0, ST_EMPTY, 5'd0, 1'b1, 1'b0, 1'b1}},
    '{OP_PUT,  32'h0000_0001, 1'b1, 1'b0, '0}
  };

  // Directed rows for the closing phase, run on a full FIFO of length 16.
  // A close without draining keeps the words, later puts and gets fail, peek
  // still works, a draining close empties all sixteen words in one burst and
  // a repeated close on the empty FIFO yields a single result.
  localparam fifo_row_t CLOSE_ROWS [11] = '{
    '{OP_PUT,   32'hDEAD_BEEF, 1'b0, 1'b1,
      '{32'h0, 1'b0, ST_FULL, 5'd16, 1'b0, 1'b1, 1'b1}},
    '{OP_PEEK,  32'h0000_0000, 1'b1, 1'b0, '0},
    '{OP_CLOSE, 32'h0000_0000, 1'b0, 1'b1,
      '{32'h0, 1'b0, ST_OK, 5'd16, 1'b0, 1'b1, 1'b1}},
    '{OP_PUT,   32'hFFFF_FFFF, 1'b0, 1'b1,
      '{32'h0, 1'b0, ST_CLOSED, 5'd16, 1'b0, 1'b1, 1'b1}},
    '{OP_GET,   32'h0000_0000, 1'b1, 1'b1,
      '{32'h0, 1'b0, ST_CLOSED, 5'd16, 1'b0, 1'b1, 1'b1}},
    '{OP_PEEK,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{OP_CLOSE, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{OP_CLOSE, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{32'h0, 1'b0, ST_OK, 5'd0, 1'b1, 1'b0, 1'b1}},
    '{OP_GET,   32'h0000_0000, 1'b0, 1'b1,
      '{32'h0, 1'b0, ST_CLOSED, 5'd0, 1'b1, 1'b0, 1'b1}},
    '{OP_PUT,   32'h8000_0001, 1'b1, 1'b1,
      '{32'h0, 1'b0, ST_CLOSED, 5'd0, 1'b1, 1'b0, 1'b1}},
    '{OP_PEEK,  32'h0000_0000, 1'b0, 1'b1,
      '{32'h0, 1'b0, ST_OK, 5'd0, 1'b1, 1'b0, 1'b1}}
  };

  // Every input of the block starts at a known value.
  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [2:0]        paddr          = '0;
  logic [PORT_W-1:0] pwdata         = '0;
  logic [PORT_W-1:0] prdata;
  logic              pready;
  logic              item_valid     = 1'b0;
  logic              item_stall;
  logic [1:0]        operation      = OP_PUT;
  logic [PORT_W-1:0] data_in        = '0;
  logic              drain_on_close = 1'b0;
  logic              result_valid;
  logic              result_stall   = 1'b0;
  logic [PORT_W-1:0] data_out;
  logic              data_valid;
  logic [1:0]        status;
  logic [LEN_W-1:0]  occupancy;
  logic              empty_flag;
  logic              full_flag;
  logic              last;

  circular_fifo_with_close_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .data_in        (data_in),
    .drain_on_close (drain_on_close),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .data_out       (data_out),
    .data_valid     (data_valid),
    .status         (status),
    .occupancy      (occupancy),
    .empty_flag     (empty_flag),
    .full_flag      (full_flag),
    .last           (last)
  );

  always #5 clk = ~clk;

  wire item_xfer   = item_valid && !item_stall;
  wire result_xfer = result_valid && !result_stall;

  // Predictor state: our own copy of the ring, its pointers, the fill count,
  // the closed flag and the active length.
  logic [31:0] ring_words [16];
  logic [3:0]  rd_slot;
  logic [3:0]  wr_slot;
  logic [4:0]  fill;
  logic        is_closed;
  logic [4:0]  active_len;

  // Results of the item just predicted, and results still owed by the FIFO.
  fifo_result_t step_results [$];
  fifo_result_t owed_results [$];

  int error_count   = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int burst_len     = 0;
  int longest_burst = 0;

  // Stimulus controls. The main process raises hold_asked to request a long
  // hold-off; the receiver process alone counts the cycles of that hold.
  bit quiet_tx    = 1'b0;
  bit quiet_rx    = 1'b0;
  int hold_asked  = 0;
  int hold_served = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("MISMATCH at %0t, result %0d: %s", $realtime, results_seen, what);
  endtask

  function automatic logic [3:0] next_slot(input logic [3:0] p);
    return (5'(p) + 5'd1 >= active_len) ? 4'd0 : p + 4'd1;
  endfunction

  function automatic void add_result(input logic [31:0] w, input logic v,
                                     input resp_code_t s, input logic l);
    fifo_result_t r;
    r.word       = v ? w : 32'h0;
    r.word_valid = v;
    r.status     = s;
    r.occ        = fill;
    r.empty      = (fill == 5'd0);
    r.full       = (fill == active_len);
    r.last       = l;
    step_results.push_back(r);
  endfunction

  // Applies one operation to the predictor state and collects what it causes.
  function automatic void fifo_model_step(input op_t op, input logic [31:0] d,
                                          input logic drain);
    logic [31:0] w;
    step_results.delete();
    case (op)
      OP_PUT: begin
        if (is_closed) begin
          add_result(32'h0, 1'b0, ST_CLOSED, 1'b1);
        end else if (fill >= active_len) begin
          add_result(32'h0, 1'b0, ST_FULL, 1'b1);
        end else begin
          ring_words[wr_slot] = d;
          wr_slot = next_slot(wr_slot);
          fill++;
          add_result(32'h0, 1'b0, ST_OK, 1'b1);
        end
      end
      OP_GET: begin
        if (is_closed) begin
          add_result(32'h0, 1'b0, ST_CLOSED, 1'b1);
        end else if (fill == 5'd0) begin
          add_result(32'h0, 1'b0, ST_EMPTY, 1'b1);
        end else begin
          w = ring_words[rd_slot];
          rd_slot = next_slot(rd_slot);
          fill--;
          add_result(w, 1'b1, ST_OK, 1'b1);
        end
      end
      OP_PEEK: begin
        if (fill != 5'd0)
          add_result(ring_words[rd_slot], 1'b1, ST_OK, 1'b1);
        else
          add_result(32'h0, 1'b0, ST_OK, 1'b1);
      end
      default: begin
        is_closed = 1'b1;
        if (drain && fill != 5'd0) begin
          while (fill != 5'd0) begin
            w = ring_words[rd_slot];
            rd_slot = next_slot(rd_slot);
            fill--;
            add_result(w, 1'b1, ST_OK, fill == 5'd0);
          end
        end else begin
          add_result(32'h0, 1'b0, ST_OK, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6)
      return 32'h0000_0000;
    if (roll < 12)
      return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // All stimulus tasks start and end just after a falling edge, so every
  // input changes only there. Valid stays high between back-to-back
  // transfers and is lowered only when a gap is chosen or offering stops, so
  // it never gets two assignments in one step.
  task automatic send_item(input op_t op, input logic [31:0] d, input logic drain,
                           input logic use_typed, input fifo_result_t typed_want);
    while (!quiet_tx && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid     <= 1'b1;
    operation      <= op;
    data_in        <= d;
    drain_on_close <= drain;
    @(posedge clk);
    while (item_stall)
      @(posedge clk);
    // The transfer happened at this edge, so predict it now.
    fifo_model_step(op, d, drain);
    if (use_typed) begin
      owed_results.push_back(typed_want);
    end else begin
      foreach (step_results[k])
        owed_results.push_back(step_results[k]);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic run_rows(input fifo_row_t rows [11]);
    foreach (rows[i])
      send_item(rows[i].op, rows[i].data, rows[i].drain, rows[i].typed, rows[i].want);
  endtask

  // Stops offering items and waits until every owed result has come back.
  // Each item causes at least one result, so an empty list means the FIFO
  // has nothing left in flight.
  task automatic wait_results();
    item_valid <= 1'b0;
    while (owed_results.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Pulls the stored words out with gets so the next length write takes
  // effect, then lets the FIFO go idle.
  task automatic empty_and_settle();
    while (fill != 5'd0)
      send_item(OP_GET, pick_word(), 1'($urandom_range(1)), 1'b0, '0);
    wait_results();
  endtask

  // Setup cycle, then access cycle; the register is written at the edge
  // where the access completes. The predictor follows the same rule as the
  // block: the write only counts while the FIFO is empty, and it clamps.
  task automatic write_length(input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_QUEUE_LENGTH, 2'b00};
    pwdata  <= PORT_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    if (fill == 5'd0) begin
      if (value == 5'd0)
        active_len = 5'd1;
      else if (value > 5'd16)
        active_len = 5'd16;
      else
        active_len = value;
      rd_slot = 4'd0;
      wr_slot = 4'd0;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random traffic on an open FIFO. The mix swings between put-heavy and
  // get-heavy stretches so that the ring fills, wraps and empties again.
  task automatic open_traffic(input int count);
    int unsigned roll;
    bit          put_heavy;
    op_t         op;
    put_heavy = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 16 == 15)
        put_heavy = !put_heavy;
      roll = $urandom_range(99);
      if (put_heavy)
        op = (roll < 65) ? OP_PUT : (roll < 90) ? OP_GET : OP_PEEK;
      else
        op = (roll < 25) ? OP_PUT : (roll < 85) ? OP_GET : OP_PEEK;
      send_item(op, pick_word(), 1'($urandom_range(1)), 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, a quiet stretch on request, and the long
  // hold-off whose cycles are counted here.
  always begin
    @(negedge clk);
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      result_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
    end
    result_stall <= !quiet_rx && ($urandom_range(99) < IDLE_PCT);
  end

  // Result checker: each transfer is compared field by field with the
  // oldest owed result.
  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (!rst && result_xfer) begin
      results_seen++;
      burst_len++;
      if (last === 1'b1) begin
        if (burst_len > longest_burst)
          longest_burst = burst_len;
        burst_len = 0;
      end
      if (owed_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = owed_results.pop_front();
        if (data_out !== want.word)
          report_mismatch($sformatf("data_out %h, wanted %h", data_out, want.word));
        if (data_valid !== want.word_valid)
          report_mismatch($sformatf("data_valid %b, wanted %b", data_valid,
                                    want.word_valid));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %s", status, want.status.name()));
        if (occupancy !== want.occ)
          report_mismatch($sformatf("occupancy %0d, wanted %0d", occupancy, want.occ));
        if (empty_flag !== want.empty)
          report_mismatch($sformatf("empty_flag %b, wanted %b", empty_flag, want.empty));
        if (full_flag !== want.full)
          report_mismatch($sformatf("full_flag %b, wanted %b", full_flag, want.full));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, wanted %b", last, want.last));
      end
    end
  end

  // Watchdog: counts cycles in which no transfer happens on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || item_xfer || result_xfer)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin : main
    logic [4:0] mid_len;
    rd_slot    = 4'd0;
    wr_slot    = 4'd0;
    fill       = 5'd0;
    is_closed  = 1'b0;
    active_len = 5'd16;
    mid_len    = 5'($urandom_range(15, 3));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part on the open FIFO; it leaves one word stored.
    run_rows(OPEN_ROWS);
    wait_results();

    // This write arrives while a word is stored, so the length stays 16.
    write_length(5'd1);
    open_traffic(30);

    // Shortest ring, written directly and then through the zero clamp.
    empty_and_settle();
    write_length(5'd1);
    open_traffic(30);
    empty_and_settle();
    write_length(5'd0);
    open_traffic(25);

    // Pressure: the receiver holds off while items keep coming, so the
    // output register fills and the item channel stalls.
    empty_and_settle();
    write_length(5'd4);
    hold_asked++;
    open_traffic(40);

    // A stretch with no idling on either side.
    empty_and_settle();
    write_length(5'd2);
    quiet_tx = 1'b1;
    quiet_rx = 1'b1;
    open_traffic(40);
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;

    empty_and_settle();
    write_length(mid_len);
    open_traffic(40);
    empty_and_settle();
    write_length(5'd16);
    open_traffic(50);

    // Closing phase: a value above the depth clamps to 16, the ring is
    // filled to the brim and then closed, kept and drained.
    empty_and_settle();
    write_length(5'd31);
    while (fill < active_len)
      send_item(OP_PUT, pick_word(), 1'($urandom_range(1)), 1'b0, '0);
    run_rows(CLOSE_ROWS);

    // Random items on the closed, empty FIFO, closes included.
    for (int n = 0; n < 30; n++)
      send_item(op_t'($urandom_range(3)), pick_word(), 1'($urandom_range(1)), 1'b0, '0);

    wait_results();
    repeat (8) @(posedge clk);
    if (owed_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                owed_results.size()));

    $display("Covered %0d items and %0d results; longest result burst %0d.",
             items_sent, results_seen, longest_burst);
    $display("Ring lengths 1, 2, 4, %0d and 16 with clamping, a long hold-off, close.",
             mid_len);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
